[rtl/indexed_search_queue_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the indexed search queue
// Concurrent check wrappers, removable by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEARCH_QUEUE_TOP_MACROS_SVH
`define INDEXED_SEARCH_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked on aclk, off during reset
`define ISQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("isq check failed");

// next-cycle implication
`define ISQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("isq check failed");

`else

`define ISQ_ASSERT_IMP(lbl, ante, cons)
`define ISQ_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[rtl/isq_pkg.sv]
// ----------------------------------------------------------------------------
// isq_pkg
// Types and constants for the indexed search queue.
// ----------------------------------------------------------------------------
package isq_pkg;

    localparam int ISQ_DEPTH      = 16;
    localparam int ISQ_DATA_WIDTH = 64;

    // stream payload widths (fields padded to whole bytes)
    localparam int ACTION_W   = 3;
    localparam int INDEX_W    = 4;
    localparam int REC_W      = 64;
    localparam int STATUS_W   = 3;
    localparam int POS_W      = 5;
    localparam int COUNT_W    = 5;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 80;
    localparam int M_PAD_W    = M_TDATA_W - STATUS_W - REC_W - POS_W - COUNT_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_TAKE   = 3'd3,
        ACT_PEEK   = 3'd4,
        ACT_FIND   = 3'd5,
        ACT_CLEAR  = 3'd6,
        ACT_LENGTH = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_RANGE    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_SHIFT,
        S_FIND,
        S_RESULT
    } state_t;

endpackage

[rtl/indexed_search_queue_top.sv]
// ----------------------------------------------------------------------------
// indexed_search_queue_top
// Bounded ordered queue with push/pop, indexed delete/take/peek, find,
// clear and length. Entries live in one 1R1W synchronous memory.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Ports                       | Payload (low bit first)
// ---------+-----+-----------------------------+-------------------------------
// request  | in  | s_tvalid s_tready s_tdata   | action[2:0] index[6:3]
//          |     |                             | data_in[70:7] pad[71]
// result   | out | m_tvalid m_tready m_tdata   | status[2:0] data_out[66:3]
//          |     |                             | position[71:67] count[76:72]
//
// Flow: push, clear, length and failed actions go from S_DECODE to S_RESULT;
//   pop and peek pass through S_FETCH; delete/take pass through S_FETCH and
//   then S_SHIFT for each entry moved down; find stays in S_FIND for each
//   entry compared. Each entry moved or compared uses the single memory read port.
// Reset: aresetn low empties the queue at once; no clearing pass is needed.
// Stalls: a finished result sits in the output register, so the next request
//   is taken while m_tready is low; a second result waits in S_RESULT.
// ----------------------------------------------------------------------------
`include "indexed_search_queue_top_macros.svh"

module indexed_search_queue_top #(
    parameter int DEPTH      = isq_pkg::ISQ_DEPTH,
    parameter int DATA_WIDTH = isq_pkg::ISQ_DATA_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // action, index, data_in
    input  logic [isq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // status, data_out, position, count
    output logic [isq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    import isq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);   // holds 0..DEPTH
    localparam int PTR_W = $clog2(DEPTH);       // physical slot
    localparam int SUM_W = PTR_W + 1;           // head + logical, < 2*DEPTH
    localparam int CMP_W = CNT_W + INDEX_W;

    // ---------------------------------------------------------------- state
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [PTR_W-1:0]        head_reg, head_next;   // physical slot of logical 0
    logic [CNT_W-1:0]        k_reg, k_next;         // logical cursor of a walk

    // captured request
    action_t                 act_reg, act_next;
    logic [INDEX_W-1:0]      idx_reg, idx_next;
    logic [DATA_WIDTH-1:0]   rec_reg, rec_next;

    // result being built
    status_t                 res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0]   res_data_reg, res_data_next;
    logic [CNT_W-1:0]        res_pos_reg, res_pos_next;

    // output register
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic                    m_load;

    // memory
    logic [DATA_WIDTH-1:0]   mem [DEPTH];
    logic [DATA_WIDTH-1:0]   rd_data_reg;
    logic                    wr_en;
    logic [DATA_WIDTH-1:0]   res_wr_data;
    logic [CNT_W-1:0]        wr_log, rd_log;        // logical positions
    logic [PTR_W-1:0]        wr_addr, rd_addr;      // physical slots
    logic [SUM_W-1:0]        wr_sum, rd_sum;

    // ---------------------------------------------------------------- helpers
    logic                    s_accept, out_free;
    logic                    is_empty, is_full, idx_ok;
    logic [CNT_W-1:0]        k_plus1, k_plus2;
    logic                    more1, more2, rd_match;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign idx_ok   = (CMP_W'(idx_reg) < CMP_W'(count_reg));
    // k stays below count during walks, so these never wrap
    assign k_plus1  = k_reg + CNT_W'(1);
    assign k_plus2  = k_reg + CNT_W'(2);
    assign more1    = (k_plus1 < count_reg);
    assign more2    = (k_plus2 < count_reg);
    assign rd_match = (rd_data_reg == rec_reg);

    // logical -> physical: one compare-subtract around the ring
    assign wr_sum  = SUM_W'(head_reg) + SUM_W'(wr_log);
    assign rd_sum  = SUM_W'(head_reg) + SUM_W'(rd_log);
    assign wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
                                               : PTR_W'(wr_sum);
    assign rd_addr = (rd_sum >= SUM_W'(DEPTH)) ? PTR_W'(rd_sum - SUM_W'(DEPTH))
                                               : PTR_W'(rd_sum);

    // ---------------------------------------------------------------- memory
    // Walks write slot k while reading k+2, so no read hits a pending write.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= res_wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (act_reg) inside
                    ACT_PUSH, ACT_CLEAR, ACT_LENGTH: state_next = S_RESULT;
                    ACT_POP: state_next = is_empty ? S_RESULT : S_FETCH;
                    ACT_DELETE, ACT_TAKE, ACT_PEEK:
                        state_next = (is_empty || !idx_ok) ? S_RESULT : S_FETCH;
                    ACT_FIND: state_next = is_empty ? S_RESULT : S_FIND;
                    default: state_next = S_RESULT;
                endcase
            end
            S_FETCH: begin
                if ((act_reg == ACT_DELETE || act_reg == ACT_TAKE) && more1)
                    state_next = S_SHIFT;
                else
                    state_next = S_RESULT;
            end
            S_SHIFT: begin
                state_next = more2 ? S_SHIFT : S_RESULT;
            end
            S_FIND: begin
                state_next = (!rd_match && more1) ? S_FIND : S_RESULT;
            end
            S_RESULT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        count_next      = count_reg;
        head_next       = head_reg;
        k_next          = k_reg;
        act_next        = act_reg;
        idx_next        = idx_reg;
        rec_next        = rec_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_pos_next    = res_pos_reg;
        wr_en           = 1'b0;
        wr_log          = k_reg;
        res_wr_data     = rd_data_reg;
        rd_log          = k_plus1;
        m_load          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    act_next = action_t'(s_tdata[ACTION_W-1:0]);
                    idx_next = s_tdata[ACTION_W +: INDEX_W];
                    rec_next = s_tdata[ACTION_W + INDEX_W +: DATA_WIDTH];
                end
            end
            S_DECODE: begin
                res_status_next = ST_OK;
                res_data_next   = '0;
                res_pos_next    = '0;
                unique case (act_reg) inside
                    ACT_PUSH: begin
                        if (is_full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            wr_en        = 1'b1;
                            wr_log       = count_reg;
                            res_wr_data  = rec_reg;
                            res_pos_next = count_reg;
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end
                    ACT_POP: begin
                        rd_log = '0;
                        k_next = '0;
                        if (is_empty) res_status_next = ST_EMPTY;
                    end
                    ACT_DELETE, ACT_TAKE, ACT_PEEK: begin
                        rd_log = CNT_W'(idx_reg);
                        k_next = CNT_W'(idx_reg);
                        if (is_empty)
                            res_status_next = ST_EMPTY;
                        else if (!idx_ok)
                            res_status_next = ST_RANGE;
                        else
                            res_pos_next = CNT_W'(idx_reg);
                    end
                    ACT_FIND: begin
                        rd_log = '0;
                        k_next = '0;
                        if (is_empty) res_status_next = ST_EMPTY;
                    end
                    ACT_CLEAR: begin
                        res_pos_next = count_reg;
                        count_next   = '0;
                    end
                    default: ;  // length: report only
                endcase
            end
            S_FETCH: begin
                // rd_data_reg holds entry k
                res_data_next = (act_reg == ACT_DELETE) ? '0 : rd_data_reg;
                unique case (act_reg) inside
                    ACT_POP: begin
                        head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                    : head_reg + PTR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                    ACT_PEEK: ;
                    default: begin
                        if (!more1) count_next = count_reg - CNT_W'(1);
                    end
                endcase
            end
            S_SHIFT: begin
                // rd_data_reg holds entry k+1: move it down to k
                wr_en  = 1'b1;
                wr_log = k_reg;
                k_next = k_plus1;
                rd_log = k_plus2;
                if (!more2) count_next = count_reg - CNT_W'(1);
            end
            S_FIND: begin
                // rd_data_reg holds entry k
                if (rd_match) begin
                    res_pos_next = k_reg;
                end else if (more1) begin
                    k_next = k_plus1;
                    rd_log = k_plus1;
                end else begin
                    res_status_next = ST_NOTFOUND;
                end
            end
            S_RESULT: begin
                m_load = out_free;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            if (m_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        rec_reg        <= rec_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_pos_reg    <= res_pos_next;
        if (m_load) begin
            m_tdata_reg <= {M_PAD_W'(0), COUNT_W'(count_reg), POS_W'(res_pos_reg),
                            REC_W'(res_data_reg), res_status_reg};
        end
    end

    // ---------------------------------------------------------------- checks
    `ISQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ISQ_ASSERT_IMP(a_full_only_at_depth, state_reg == S_RESULT && res_status_reg == ST_FULL,
                    count_reg == CNT_W'(DEPTH))
    `ISQ_ASSERT_IMP(a_shift_in_range, state_reg == S_SHIFT, more1)
    `ISQ_ASSERT_NXT(a_load_sets_valid, m_load, m_tvalid_reg)

endmodule
